>>> rtl/core/incremental_pid_filtered_d_unit_assert.svh
// Assertion macros for the incremental PID unit
`ifndef INCREMENTAL_PID_FILTERED_D_UNIT_ASSERT_SVH
`define INCREMENTAL_PID_FILTERED_D_UNIT_ASSERT_SVH

// same-cycle implication
`define PIDFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pidfd same-cycle check failed");

// next-cycle implication
`define PIDFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pidfd next-cycle check failed");

`endif

>>> rtl/core/pidfd_pkg.sv
// Package: types, constants and codes of the incremental PID unit
`timescale 1ns / 1ps

package pidfd_pkg;

    localparam int ERR_W   = 17;
    localparam int GAIN_W  = 24;
    localparam int STEP_W  = 31;
    localparam int OUT_W   = 32;
    localparam int MUL_AW  = 32;
    localparam int MUL_BW  = 24;
    localparam int PROD_W  = MUL_AW + MUL_BW;
    localparam int PI_W    = 44;
    localparam int IDX_W   = 3;

    localparam logic signed [MUL_BW-1:0] ALPHA_Q16           = 24'sd58982;
    localparam logic signed [MUL_BW-1:0] ONE_MINUS_ALPHA_Q16 = 24'sd6554;
    localparam logic signed [PROD_W-1:0] HALF_Q16            = 56'sd32768;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_STEP_LIMIT = 3'd3,
        REG_OUT_UPPER  = 3'd4,
        REG_OUT_LOWER  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic        [STEP_W-1:0] step_limit;
        logic signed [OUT_W-1:0]  out_upper;
        logic signed [OUT_W-1:0]  out_lower;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_I,
        S_MUL_F,
        S_MUL_M,
        S_MUL_D,
        S_FILT,
        S_STEP,
        S_ACC
    } t_seq_state;

    typedef struct packed {
        t_seq_state step;
        logic       in_ready;
        logic       commit;
    } t_seq_ctrl;

endpackage

>>> rtl/core/pidfd_in_if.sv
// Input channel: update or restart item
`timescale 1ns / 1ps

interface pidfd_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic signed [15:0] target;
    logic signed [15:0] measured;

    modport source (output valid, output cmd, output target, output measured, input ready);
    modport sink   (input valid, input cmd, input target, input measured, output ready);
endinterface

>>> rtl/core/pidfd_out_if.sv
// Output channel: controller drive item
`timescale 1ns / 1ps

interface pidfd_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] drive;
    logic        at_limit;

    modport source (output valid, output drive, output at_limit, input ready);
    modport sink   (input valid, input drive, input at_limit, output ready);
endinterface

>>> rtl/core/pidfd_cfg.sv
// Configuration register file of the incremental PID unit
`timescale 1ns / 1ps

module pidfd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [pidfd_pkg::IDX_W-1:0]         i_index,
    input  logic [pidfd_pkg::OUT_W-1:0]         i_data,
    output pidfd_pkg::t_cfg                     o_cfg
);

    pidfd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p     <= '0;
            r_cfg.gain_i     <= '0;
            r_cfg.gain_d     <= '0;
            r_cfg.step_limit <= 31'd65536;
            r_cfg.out_upper  <= 32'sh7FFF_FFFF;
            r_cfg.out_lower  <= '0;
        end else if (i_wr_en) begin
            unique case (i_index)
                pidfd_pkg::REG_GAIN_P:     r_cfg.gain_p     <= i_data[pidfd_pkg::GAIN_W-1:0];
                pidfd_pkg::REG_GAIN_I:     r_cfg.gain_i     <= i_data[pidfd_pkg::GAIN_W-1:0];
                pidfd_pkg::REG_GAIN_D:     r_cfg.gain_d     <= i_data[pidfd_pkg::GAIN_W-1:0];
                pidfd_pkg::REG_STEP_LIMIT: r_cfg.step_limit <= i_data[pidfd_pkg::STEP_W-1:0];
                pidfd_pkg::REG_OUT_UPPER:  r_cfg.out_upper  <= i_data;
                pidfd_pkg::REG_OUT_LOWER:  r_cfg.out_lower  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/pidfd_mul.sv
// Shared signed multiplier with registered product
`timescale 1ns / 1ps

module pidfd_mul (
    input  logic                                    i_clk,
    input  logic signed [pidfd_pkg::MUL_AW-1:0]     i_a,
    input  logic signed [pidfd_pkg::MUL_BW-1:0]     i_b,
    output logic signed [pidfd_pkg::PROD_W-1:0]     o_prod
);

    logic signed [pidfd_pkg::PROD_W-1:0] r_prod;
    logic signed [pidfd_pkg::PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = pidfd_pkg::PROD_W'(i_a) * pidfd_pkg::PROD_W'(i_b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/core/pidfd_seq.sv
// Sequencer that steps one item through the shared multiplier
`timescale 1ns / 1ps

module pidfd_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_cmd,
    input  logic                    i_out_free,
    output pidfd_pkg::t_seq_ctrl    o_ctrl
);

    pidfd_pkg::t_seq_state r_state;
    pidfd_pkg::t_seq_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pidfd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_cmd ? pidfd_pkg::S_ACC : pidfd_pkg::S_MUL_P;
                end
            end
            pidfd_pkg::S_MUL_P: n_state = pidfd_pkg::S_MUL_I;
            pidfd_pkg::S_MUL_I: n_state = pidfd_pkg::S_MUL_F;
            pidfd_pkg::S_MUL_F: n_state = pidfd_pkg::S_MUL_M;
            pidfd_pkg::S_MUL_M: n_state = pidfd_pkg::S_MUL_D;
            pidfd_pkg::S_MUL_D: n_state = pidfd_pkg::S_FILT;
            pidfd_pkg::S_FILT:  n_state = pidfd_pkg::S_STEP;
            pidfd_pkg::S_STEP:  n_state = pidfd_pkg::S_ACC;
            pidfd_pkg::S_ACC: begin
                if (i_out_free) begin
                    n_state = pidfd_pkg::S_IDLE;
                end
            end
            default: n_state = pidfd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pidfd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctrl.step     = r_state;
        o_ctrl.in_ready = (r_state == pidfd_pkg::S_IDLE) && i_rst_n;
        o_ctrl.commit   = (r_state == pidfd_pkg::S_ACC) && i_out_free;
    end

endmodule

>>> rtl/core/incremental_pid_filtered_d_unit.sv
// Top level of the incremental PID unit with low-pass filtered derivative
// Velocity-form PID controller in fixed point: each update item forms
// e = target - measured and adds the clamped increment
// gain_p*(e-e1) + gain_i*e (gated off while the output sits at a clamp)
// + a low-pass filtered gain_d*(e-2*e1+e2) to the output, which is then
// clamped to [out_lower, out_upper]; a restart item clears the history and
// the filter and sets the output to out_lower. An update item steps through
// S_MUL_P, S_MUL_I, S_MUL_F, S_MUL_M and S_MUL_D (five products through the
// one 32x24 multiplier), then S_FILT, S_STEP and S_ACC, where its result is
// committed to the output register; a restart item goes from S_IDLE straight
// to S_ACC. A new item is taken only once the last one is through and the
// sequencer is back in S_IDLE. The input is not ready while an item is in
// work or during reset. A finished result sits in an output register, so
// the next item is accepted while it waits; the block only stalls if a new
// result is due before the last one is taken.
// Configuration writes must occur only while the block is idle.
`timescale 1ns / 1ps

module incremental_pid_filtered_d_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [pidfd_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [pidfd_pkg::OUT_W-1:0] i_cfg_data,
    pidfd_in_if.sink                    i_in,
    pidfd_out_if.source                 o_out
);

    `include "incremental_pid_filtered_d_unit_assert.svh"

    pidfd_pkg::t_cfg      cfg;
    pidfd_pkg::t_seq_ctrl ctrl;

    logic signed [pidfd_pkg::MUL_AW-1:0] mul_a;
    logic signed [pidfd_pkg::MUL_BW-1:0] mul_b;
    logic signed [pidfd_pkg::PROD_W-1:0] prod;

    logic signed [pidfd_pkg::ERR_W-1:0]  r_err;
    logic signed [pidfd_pkg::ERR_W-1:0]  r_e1;
    logic signed [pidfd_pkg::ERR_W-1:0]  r_e2;
    logic signed [pidfd_pkg::OUT_W-1:0]  r_dfilt;
    logic signed [pidfd_pkg::OUT_W-1:0]  r_drive;
    logic signed [pidfd_pkg::PI_W-1:0]   r_pi;
    logic signed [pidfd_pkg::PROD_W-1:0] r_fsum;
    logic signed [pidfd_pkg::OUT_W-1:0]  r_delta;
    logic                                r_restart;
    logic                                r_out_valid;
    logic signed [pidfd_pkg::OUT_W-1:0]  r_out_drive;
    logic                                r_out_lim;

    logic                                accept;
    logic                                out_free;
    logic signed [pidfd_pkg::ERR_W:0]    diff1;
    logic signed [pidfd_pkg::ERR_W+1:0]  diff2;
    logic                                aw;
    logic signed [pidfd_pkg::PROD_W:0]   filt_sum;
    logic signed [pidfd_pkg::PROD_W-16:0] filt_shr;
    logic signed [pidfd_pkg::OUT_W-1:0]  n_dfilt;
    logic signed [pidfd_pkg::PI_W:0]     delta_wide;
    logic signed [pidfd_pkg::PI_W:0]     step_pos;
    logic signed [pidfd_pkg::PI_W:0]     step_neg;
    logic signed [pidfd_pkg::OUT_W-1:0]  n_delta;
    logic signed [pidfd_pkg::OUT_W:0]    acc_wide;
    logic signed [pidfd_pkg::OUT_W-1:0]  n_drive;
    logic                                n_lim;

    pidfd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign out_free = !r_out_valid || o_out.ready;

    pidfd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_cmd      (i_in.cmd),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    pidfd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign accept = i_in.valid && ctrl.in_ready;

    always_comb begin
        diff1 = (pidfd_pkg::ERR_W+1)'(r_err) - (pidfd_pkg::ERR_W+1)'(r_e1);
        diff2 = (pidfd_pkg::ERR_W+2)'(r_err)
              - $signed({r_e1[pidfd_pkg::ERR_W-1], r_e1, 1'b0})
              + (pidfd_pkg::ERR_W+2)'(r_e2);
        aw    = !((r_drive >= cfg.out_upper) || (r_drive <= cfg.out_lower));
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.step)
            pidfd_pkg::S_MUL_P: begin
                mul_a = pidfd_pkg::MUL_AW'(diff1);
                mul_b = cfg.gain_p;
            end
            pidfd_pkg::S_MUL_I: begin
                mul_a = pidfd_pkg::MUL_AW'(r_err);
                mul_b = cfg.gain_i;
            end
            pidfd_pkg::S_MUL_F: begin
                mul_a = r_dfilt;
                mul_b = pidfd_pkg::ALPHA_Q16;
            end
            pidfd_pkg::S_MUL_M: begin
                mul_a = pidfd_pkg::MUL_AW'(diff2);
                mul_b = pidfd_pkg::ONE_MINUS_ALPHA_Q16;
            end
            pidfd_pkg::S_MUL_D: begin
                mul_a = prod[pidfd_pkg::MUL_AW-1:0];
                mul_b = cfg.gain_d;
            end
            default: ;
        endcase
    end

    always_comb begin
        filt_sum = (pidfd_pkg::PROD_W+1)'(r_fsum) + (pidfd_pkg::PROD_W+1)'(prod);
        filt_shr = filt_sum[pidfd_pkg::PROD_W:16];
        if ((&filt_shr[pidfd_pkg::PROD_W-16:pidfd_pkg::OUT_W-1])
                || !(|filt_shr[pidfd_pkg::PROD_W-16:pidfd_pkg::OUT_W-1])) begin
            n_dfilt = filt_shr[pidfd_pkg::OUT_W-1:0];
        end else if (filt_shr[pidfd_pkg::PROD_W-16]) begin
            n_dfilt = {1'b1, {(pidfd_pkg::OUT_W-1){1'b0}}};
        end else begin
            n_dfilt = {1'b0, {(pidfd_pkg::OUT_W-1){1'b1}}};
        end
    end

    always_comb begin
        delta_wide = (pidfd_pkg::PI_W+1)'(r_pi) + (pidfd_pkg::PI_W+1)'(r_dfilt);
        step_pos   = $signed({{(pidfd_pkg::PI_W+1-pidfd_pkg::STEP_W){1'b0}}, cfg.step_limit});
        step_neg   = -step_pos;
        if (delta_wide > step_pos) begin
            n_delta = step_pos[pidfd_pkg::OUT_W-1:0];
        end else if (delta_wide < step_neg) begin
            n_delta = step_neg[pidfd_pkg::OUT_W-1:0];
        end else begin
            n_delta = delta_wide[pidfd_pkg::OUT_W-1:0];
        end
    end

    always_comb begin
        acc_wide = (pidfd_pkg::OUT_W+1)'(r_drive) + (pidfd_pkg::OUT_W+1)'(r_delta);
        if (r_restart) begin
            n_drive = cfg.out_lower;
        end else if (acc_wide > (pidfd_pkg::OUT_W+1)'(cfg.out_upper)) begin
            n_drive = cfg.out_upper;
            if (cfg.out_upper < cfg.out_lower) begin
                n_drive = cfg.out_lower;
            end
        end else if (acc_wide < (pidfd_pkg::OUT_W+1)'(cfg.out_lower)) begin
            n_drive = cfg.out_lower;
        end else begin
            n_drive = acc_wide[pidfd_pkg::OUT_W-1:0];
        end
        n_lim = (n_drive == cfg.out_upper) || (n_drive == cfg.out_lower);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_err     <= (pidfd_pkg::ERR_W)'(i_in.target) - (pidfd_pkg::ERR_W)'(i_in.measured);
            r_restart <= i_in.cmd;
        end
        case (ctrl.step)
            pidfd_pkg::S_MUL_I: r_pi   <= pidfd_pkg::PI_W'(prod);
            pidfd_pkg::S_MUL_F: begin
                if (aw) begin
                    r_pi <= r_pi + pidfd_pkg::PI_W'(prod);
                end
            end
            pidfd_pkg::S_MUL_M: r_fsum <= prod + pidfd_pkg::HALF_Q16;
            pidfd_pkg::S_STEP:  r_delta <= n_delta;
            default: ;
        endcase
        if (ctrl.commit) begin
            r_out_drive <= n_drive;
            r_out_lim   <= n_lim;
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1        <= '0;
            r_e2        <= '0;
            r_dfilt     <= '0;
            r_drive     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctrl.step == pidfd_pkg::S_FILT) begin
                r_dfilt <= n_dfilt;
            end
            if (ctrl.commit) begin
                r_drive     <= n_drive;
                r_out_valid <= 1'b1;
                if (r_restart) begin
                    r_e1    <= '0;
                    r_e2    <= '0;
                    r_dfilt <= '0;
                end else begin
                    r_e1 <= r_err;
                    r_e2 <= r_e1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_in.ready     = ctrl.in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.drive    = r_out_drive;
    assign o_out.at_limit = r_out_lim;

    `PIDFD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !i_in.ready)
    `PIDFD_ASSERT_NOW(a_drive_in_range, i_clk, i_rst_n, o_out.valid && (cfg.out_lower <= cfg.out_upper), (o_out.drive >= cfg.out_lower) && (o_out.drive <= cfg.out_upper))
    `PIDFD_ASSERT_NEXT(a_restart_result, i_clk, i_rst_n, ctrl.commit && r_restart, o_out.valid && o_out.at_limit && (o_out.drive == $past(cfg.out_lower)))

endmodule

>>> sim/incremental_pid_filtered_d_unit_test.sv
// Testbench: incremental PID unit, each drive item checked against a fixed-point predictor
`timescale 1ns / 1ps

module incremental_pid_filtered_d_unit_test;

    localparam logic CMD_UPDATE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;
    localparam int   HOLD_CYCLES = 300;
    localparam int   PHASES      = 8;
    localparam int   PHASE_ITEMS = 50;
    localparam longint S32_MAX   = longint'(32'sh7FFFFFFF);
    localparam longint S32_MIN   = longint'(32'sh80000000);

    typedef struct packed {
        logic signed [31:0] drive;
        logic               at_limit;
    } t_drive;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;
    typedef enum logic {REGIME_TRACK, REGIME_WILD} t_regime;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BEAT, RX_CHOKE} t_rx_mode;

    typedef struct {
        t_row_kind           kind;
        logic                cmd;
        logic signed [15:0]  target;
        logic signed [15:0]  measured;
        bit                  fixed;
        t_drive              want;
        pidfd_pkg::t_reg_idx idx;
        logic [31:0]         data;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    pidfd_pkg::t_reg_idx cfg_index = pidfd_pkg::REG_GAIN_P;
    logic [31:0] cfg_data = '0;

    pidfd_in_if  upd_ch ();
    pidfd_out_if drv_ch ();

    incremental_pid_filtered_d_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (upd_ch),
        .o_out       (drv_ch)
    );

    // controller shadow: configuration and state
    logic signed [23:0] gp_q = '0;
    logic signed [23:0] gi_q = '0;
    logic signed [23:0] gd_q = '0;
    logic        [30:0] step_q = 31'd65536;
    logic signed [31:0] upper_q = 32'sh7FFFFFFF;
    logic signed [31:0] lower_q = '0;
    logic signed [16:0] err1 = '0;
    logic signed [16:0] err2 = '0;
    logic signed [31:0] dfilt = '0;
    logic signed [31:0] drv = '0;

    t_drive    due_drives[$];
    t_plan_row plan[$];

    int  n_items, n_restarts, n_gated, n_checked, n_at_limit, n_writes, n_holds, n_fail;
    int  burst_left;
    bit  steady;
    bit  hold_req;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_drive next_drive(logic c, logic signed [15:0] t,
                                          logic signed [15:0] m);
        longint e, p, ip, draw, mix, delta, acc, lim_step;
        t_drive r;
        if (c == CMD_RESTART) begin
            err1 = '0;
            err2 = '0;
            dfilt = '0;
            drv = lower_q;
        end else begin
            e = longint'(t) - longint'(m);
            if (drv >= upper_q || drv <= lower_q) begin
                ip = 0;
                n_gated++;
            end else begin
                ip = longint'(gi_q) * e;
            end
            p = longint'(gp_q) * (e - longint'(err1));
            draw = longint'(gd_q) * (e - 2 * longint'(err1) + longint'(err2));
            mix = longint'(pidfd_pkg::ALPHA_Q16) * longint'(dfilt)
                + longint'(pidfd_pkg::ONE_MINUS_ALPHA_Q16) * draw
                + longint'(pidfd_pkg::HALF_Q16);
            mix = mix >>> 16;
            if (mix > S32_MAX) begin
                dfilt = 32'sh7FFFFFFF;
            end else if (mix < S32_MIN) begin
                dfilt = 32'sh80000000;
            end else begin
                dfilt = mix[31:0];
            end
            delta = p + ip + longint'(dfilt);
            lim_step = longint'(step_q);
            if (delta > lim_step) delta = lim_step;
            if (delta < -lim_step) delta = -lim_step;
            acc = longint'(drv) + delta;
            if (acc > longint'(upper_q)) acc = longint'(upper_q);
            if (acc < longint'(lower_q)) acc = longint'(lower_q);
            drv = acc[31:0];
            err2 = err1;
            err1 = e[16:0];
        end
        r.drive = drv;
        r.at_limit = (drv == upper_q) || (drv == lower_q);
        return r;
    endfunction

    function automatic t_plan_row row_item(logic c, int t, int m, bit fixed,
                                           logic [31:0] d, logic lim);
        t_plan_row r;
        r.kind = ROW_ITEM;
        r.cmd = c;
        r.target = t[15:0];
        r.measured = m[15:0];
        r.fixed = fixed;
        r.want.drive = d;
        r.want.at_limit = lim;
        r.idx = pidfd_pkg::REG_GAIN_P;
        r.data = '0;
        return r;
    endfunction

    function automatic t_plan_row row_reg(pidfd_pkg::t_reg_idx idx, logic [31:0] v);
        t_plan_row r;
        r = row_item(CMD_UPDATE, 0, 0, 1'b0, '0, 1'b0);
        r.kind = ROW_REG;
        r.idx = idx;
        r.data = v;
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_fail++;
    endtask

    task automatic write_reg(pidfd_pkg::t_reg_idx idx, logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            pidfd_pkg::REG_GAIN_P:     gp_q = v[23:0];
            pidfd_pkg::REG_GAIN_I:     gi_q = v[23:0];
            pidfd_pkg::REG_GAIN_D:     gd_q = v[23:0];
            pidfd_pkg::REG_STEP_LIMIT: step_q = v[30:0];
            pidfd_pkg::REG_OUT_UPPER:  upper_q = v;
            pidfd_pkg::REG_OUT_LOWER:  lower_q = v;
            default: ;
        endcase
        n_writes++;
        @(posedge i_clk);
    endtask

    task automatic offer(logic c, logic signed [15:0] t, logic signed [15:0] m,
                         bit use_fixed, t_drive fixed_val);
        t_drive got;
        upd_ch.valid <= 1'b1;
        upd_ch.cmd <= c;
        upd_ch.target <= t;
        upd_ch.measured <= m;
        do @(posedge i_clk); while (!upd_ch.ready);
        got = next_drive(c, t, m);
        due_drives.push_back(use_fixed ? fixed_val : got);
        n_items++;
        if (c == CMD_RESTART) n_restarts++;
    endtask

    task automatic pace();
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 9);
            if (!steady) begin
                upd_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // drop valid and wait until every drive item has come back
    task automatic settle();
        upd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (due_drives.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_drive want;
        if (i_rst_n && drv_ch.valid && drv_ch.ready) begin
            if (due_drives.size() == 0) begin
                flag_mismatch($sformatf("unexpected item drive=%0d at_limit=%0b",
                                        drv_ch.drive, drv_ch.at_limit));
            end else begin
                want = due_drives.pop_front();
                n_checked++;
                if (drv_ch.at_limit) n_at_limit++;
                if (drv_ch.drive !== want.drive)
                    flag_mismatch($sformatf("item %0d drive %0d, want %0d",
                                            n_checked, drv_ch.drive, want.drive));
                if (drv_ch.at_limit !== want.at_limit)
                    flag_mismatch($sformatf("item %0d at_limit %0b, want %0b",
                                            n_checked, drv_ch.at_limit, want.at_limit));
            end
        end
    end

    initial begin
        t_rx_mode rx_mode;
        int       rx_left;
        int       rx_tick;
        rx_mode = RX_OPEN;
        rx_left = 0;
        rx_tick = 0;
        drv_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                drv_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                n_holds++;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    rx_left = $urandom_range(16, 96);
                end
                rx_left--;
                rx_tick++;
                case (rx_mode)
                    RX_OPEN:  drv_ch.ready <= 1'b1;
                    RX_COIN:  drv_ch.ready <= 1'($urandom_range(0, 1));
                    RX_BEAT:  drv_ch.ready <= (rx_tick % 5) != 0;
                    RX_CHOKE: drv_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:  drv_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[incremental_pid_filtered_d_unit] ERROR");
        $finish;
    end

    initial begin
        bit      writing;
        t_regime regime;
        logic    c;
        int      sp, tv, mv;
        int      gp, gi, gd, sl, hi, lo;

        upd_ch.valid <= 1'b0;
        upd_ch.cmd <= CMD_UPDATE;
        upd_ch.target <= '0;
        upd_ch.measured <= '0;
        writing = 1'b0;
        sp = 0;
        burst_left = 0;
        steady = 1'b0;
        hold_req = 1'b0;

        // reset values: zero gains, clamps at zero and full scale
        plan.push_back(row_item(CMD_UPDATE, 0, 0, 1'b1, 32'h0, 1'b1));
        plan.push_back(row_item(CMD_UPDATE, 32767, -32768, 1'b1, 32'h0, 1'b1));
        plan.push_back(row_item(CMD_RESTART, -1, -1, 1'b1, 32'h0, 1'b1));
        // extreme gains and limits, filter saturates both ways
        plan.push_back(row_reg(pidfd_pkg::REG_GAIN_P, 32'h007F_FFFF));
        plan.push_back(row_reg(pidfd_pkg::REG_GAIN_I, 32'h0080_0000));
        plan.push_back(row_reg(pidfd_pkg::REG_GAIN_D, 32'h007F_FFFF));
        plan.push_back(row_reg(pidfd_pkg::REG_STEP_LIMIT, 32'h7FFF_FFFF));
        plan.push_back(row_reg(pidfd_pkg::REG_OUT_UPPER, 32'h7FFF_FFFF));
        plan.push_back(row_reg(pidfd_pkg::REG_OUT_LOWER, 32'h8000_0000));
        plan.push_back(row_item(CMD_UPDATE, 32767, -32768, 1'b0, '0, 1'b0));
        plan.push_back(row_item(CMD_UPDATE, -32768, 32767, 1'b0, '0, 1'b0));
        plan.push_back(row_item(CMD_UPDATE, 0, 0, 1'b0, '0, 1'b0));
        plan.push_back(row_item(CMD_RESTART, 0, 0, 1'b1, 32'h8000_0000, 1'b1));
        // zero step limit holds the output
        plan.push_back(row_reg(pidfd_pkg::REG_STEP_LIMIT, 32'h0));
        plan.push_back(row_item(CMD_UPDATE, 1000, -1000, 1'b1, 32'h8000_0000, 1'b1));
        // moderate loop, ramp into the upper clamp to gate the integral
        plan.push_back(row_reg(pidfd_pkg::REG_GAIN_P, 32'h0001_0000));
        plan.push_back(row_reg(pidfd_pkg::REG_GAIN_I, 32'h0000_4000));
        plan.push_back(row_reg(pidfd_pkg::REG_GAIN_D, 32'hFFC0_0000));
        plan.push_back(row_reg(pidfd_pkg::REG_STEP_LIMIT, 32'h000A_0000));
        plan.push_back(row_reg(pidfd_pkg::REG_OUT_UPPER, 32'h0064_0000));
        plan.push_back(row_reg(pidfd_pkg::REG_OUT_LOWER, 32'hFF9C_0000));
        plan.push_back(row_item(CMD_RESTART, 0, 0, 1'b1, 32'hFF9C_0000, 1'b1));
        plan.push_back(row_item(CMD_UPDATE, 5, 0, 1'b0, '0, 1'b0));
        plan.push_back(row_item(CMD_UPDATE, 20, 0, 1'b0, '0, 1'b0));
        plan.push_back(row_item(CMD_UPDATE, 40, 0, 1'b0, '0, 1'b0));
        plan.push_back(row_item(CMD_UPDATE, 60, 0, 1'b0, '0, 1'b0));
        plan.push_back(row_item(CMD_UPDATE, 60, 0, 1'b0, '0, 1'b0));
        plan.push_back(row_item(CMD_UPDATE, 60, 0, 1'b0, '0, 1'b0));
        plan.push_back(row_item(CMD_UPDATE, -60, 0, 1'b0, '0, 1'b0));
        plan.push_back(row_item(CMD_UPDATE, -60, 0, 1'b0, '0, 1'b0));
        // crossed clamps: the lower one wins
        plan.push_back(row_reg(pidfd_pkg::REG_OUT_UPPER, 32'hFFFB_0000));
        plan.push_back(row_reg(pidfd_pkg::REG_OUT_LOWER, 32'h0005_0000));
        plan.push_back(row_item(CMD_UPDATE, 10, 0, 1'b1, 32'h0005_0000, 1'b1));
        plan.push_back(row_item(CMD_RESTART, 0, 0, 1'b1, 32'h0005_0000, 1'b1));
        plan.push_back(row_item(CMD_UPDATE, -10, 0, 1'b1, 32'h0005_0000, 1'b1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_REG) begin
                if (!writing) begin
                    settle();
                    writing = 1'b1;
                end
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                if (writing) begin
                    cfg_wr_en <= 1'b0;
                    writing = 1'b0;
                end
                offer(plan[k].cmd, plan[k].target, plan[k].measured,
                      plan[k].fixed, plan[k].want);
                pace();
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            regime = (ph % 2) ? REGIME_WILD : REGIME_TRACK;
            steady = (ph == 2) || (ph == 5);
            settle();
            if (regime == REGIME_TRACK) begin
                gp = $urandom_range(0, 196608);
                if ($urandom_range(0, 3) == 0) gp = -gp;
                gi = $urandom_range(0, 32768);
                gd = $urandom_range(0, 131072);
                if ($urandom_range(0, 1)) gd = -gd;
                sl = $urandom_range(1024, 4194304);
                hi = $urandom_range(262144, 67108864);
                lo = -int'($urandom_range(0, 67108864));
            end else begin
                gp = $urandom;
                gi = $urandom;
                gd = $urandom;
                sl = $urandom;
                hi = $urandom;
                lo = $urandom;
            end
            write_reg(pidfd_pkg::REG_GAIN_P, gp);
            write_reg(pidfd_pkg::REG_GAIN_I, gi);
            write_reg(pidfd_pkg::REG_GAIN_D, gd);
            write_reg(pidfd_pkg::REG_STEP_LIMIT, sl);
            write_reg(pidfd_pkg::REG_OUT_UPPER, hi);
            write_reg(pidfd_pkg::REG_OUT_LOWER, lo);
            cfg_wr_en <= 1'b0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // long receiver hold-off while items keep coming
                if (ph == 2 && k == 5) hold_req = 1'b1;
                c = ($urandom_range(0, 19) == 0) ? CMD_RESTART : CMD_UPDATE;
                if (regime == REGIME_WILD || $urandom_range(0, 9) == 0) begin
                    tv = $urandom;
                    mv = $urandom;
                end else begin
                    if ($urandom_range(0, 11) == 0) sp = int'($urandom_range(0, 4000)) - 2000;
                    tv = sp;
                    mv = sp + int'($urandom_range(0, 400)) - 200;
                    if ($urandom_range(0, 29) == 0) tv = $urandom_range(0, 1) ? 32767 : -32768;
                end
                offer(c, tv[15:0], mv[15:0], 1'b0, '0);
                pace();
            end
        end

        settle();
        repeat (24) @(posedge i_clk);
        if (due_drives.size() != 0)
            flag_mismatch($sformatf("%0d drive items never arrived", due_drives.size()));

        $display("run: %0d items sent (%0d restarts, %0d with integral gated), %0d register writes",
                 n_items, n_restarts, n_gated, n_writes);
        $display("run: %0d drive items checked, %0d at a clamp, %0d long receiver hold-offs",
                 n_checked, n_at_limit, n_holds);
        if (n_fail == 0) begin
            $display("[incremental_pid_filtered_d_unit] OK");
        end else begin
            $display("[incremental_pid_filtered_d_unit] ERROR");
        end
        $finish;
    end

endmodule
